@@ sv/asatm_pkg.sv @@
// ----------------------------------------------------------------------------
// asatm_pkg
// Shared types, constants and the tanh table for the saturator/tone mixer.
// ----------------------------------------------------------------------------
`default_nettype none
package asatm_pkg;

  localparam int CHANNELS         = 2;
  localparam int TANH_TABLE_DEPTH = 256;
  localparam int TBL_AW           = $clog2(TANH_TABLE_DEPTH);
  localparam int TANH_FRAC        = 26;
  localparam int QDEPTH           = 4;
  localparam int QAW              = $clog2(QDEPTH);

  localparam logic [15:0] DRIVE_MIN = 16'd2048;
  localparam logic [15:0] CAP_SOFT  = 16'd40960;
  localparam logic [15:0] CAP_TAPE  = 16'd20480;
  localparam logic [15:0] CAP_TUBE  = 16'd30720;
  localparam logic [16:0] FRAC_ONE  = 17'd65536;
  localparam logic signed [26:0] TWO_THIRDS = 27'sd5592405;
  localparam logic [31:0] RECIP3    = 32'hAAAAAAAB;
  localparam logic [63:0] TANH_STEP = (64'd16 << 32) / TANH_TABLE_DEPTH;

  typedef enum logic [1:0] {
    MODE_SOFT, MODE_TAPE, MODE_TUBE, MODE_BYPASS
  } curve_t;

  typedef enum logic [2:0] {
    REG_CURVE_MODE, REG_DRIVE_GAIN, REG_SOFT_NORM, REG_TONE_AMOUNT,
    REG_FILTER_COEFF, REG_OUTPUT_GAIN, REG_WET_MIX
  } reg_idx_t;

  typedef struct packed {
    curve_t      mode;
    logic [15:0] drive;
    logic [16:0] norm;
    logic [16:0] tone;
    logic [16:0] coef;
    logic [16:0] gain;
    logic [16:0] wet;
  } cfg_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic               ch;
    logic signed [29:0] drv;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE, B_CLASS, B_SOFT_A, B_SOFT_B, B_SOFT_C, B_TAPE_A, B_TAPE_B,
    B_TAPE_C, B_TUBE, B_FILT, B_TONE, B_GAIN, B_MIX, B_DONE
  } back_state_t;

  typedef logic [22:0] tanh_tbl_t [TANH_TABLE_DEPTH+1];

  // shift-subtract long division, used only while the table is built
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rm;
    q  = '0;
    rm = '0;
    for (int b = 63; b >= 0; b--) begin
      rm = {rm[63:0], n[b]};
      if (rm >= {1'b0, d}) begin
        rm   = rm - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic tanh_tbl_t build_tanh();
    tanh_tbl_t   t;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] p;
    logic [63:0] one;
    one  = 64'd1 << 32;
    term = one;
    acc  = one;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64((term * TANH_STEP) >> 32, 64'(k));
      acc  = k[0] ? acc - term : acc + term;
    end
    p    = one;
    t[0] = '0;
    for (int i = 1; i <= TANH_TABLE_DEPTH; i++) begin
      p    = (p * acc) >> 32;
      t[i] = 23'(udiv64((one - p) << 23, one + p));
    end
    return t;
  endfunction

  localparam tanh_tbl_t TANH_TBL = build_tanh();

  function automatic logic signed [17:0] frac_clamp(input logic [16:0] v);
    return (v > FRAC_ONE) ? $signed({1'b0, FRAC_ONE}) : $signed({1'b0, v});
  endfunction

endpackage
`default_nettype wire

@@ sv/audio_saturator_tone_mix.sv @@
// ----------------------------------------------------------------------------
// audio_saturator_tone_mix
// Waveshaping saturator with one-pole tone filter, gain and dry/wet mix.
// ----------------------------------------------------------------------------
// Push to result: soft and unclipped tape shape in their own steps, clipped tape and
// bypass go straight to filter, tube waits on a 24 bit divider (one quotient
// bit per cycle); then filter, tone, gain, mix. One request at a time; the
// sequencer holds until the last result is popped; a 4-entry queue takes
// requests meanwhile. Reset (rst, synchronous) restores the register defaults,
// clears the tone memory and the queue, and marks the result register empty.
`default_nettype none
module audio_saturator_tone_mix (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire [2:0]         cfg_index,
  input  wire [16:0]        cfg_data,
  input  wire               push,
  output logic              full,
  input  wire signed [23:0] sample_in,
  input  wire               channel,
  output logic              empty,
  input  wire               pop,
  output logic signed [23:0] sample_out,
  output logic              channel_out
);
  import asatm_pkg::*;

  cfg_t  cfg;
  logic  q_wr, q_pop, q_empty;
  item_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode  <= MODE_SOFT;
      cfg.drive <= 16'd2048;
      cfg.norm  <= 17'd48128;
      cfg.tone  <= 17'd32768;
      cfg.coef  <= 17'd4096;
      cfg.gain  <= 17'd65536;
      cfg.wet   <= 17'd32768;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CURVE_MODE:   cfg.mode  <= curve_t'(cfg_data[1:0]);
        REG_DRIVE_GAIN:   cfg.drive <= cfg_data[15:0];
        REG_SOFT_NORM:    cfg.norm  <= cfg_data;
        REG_TONE_AMOUNT:  cfg.tone  <= cfg_data;
        REG_FILTER_COEFF: cfg.coef  <= cfg_data;
        REG_OUTPUT_GAIN:  cfg.gain  <= cfg_data;
        REG_WET_MIX:      cfg.wet   <= cfg_data;
        default: ;
      endcase
    end
  end

  asatm_front u_front (
    .cfg(cfg), .push(push), .q_full(full), .sample_in(sample_in),
    .channel(channel), .q_wr(q_wr), .q_item(q_wdata)
  );

  asatm_fifo u_fifo (
    .clk(clk), .rst(rst), .wr(q_wr), .wr_data(q_wdata), .rd(q_pop),
    .rd_data(q_rdata), .full(full), .empty(q_empty)
  );

  asatm_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_empty(q_empty), .q_item(q_rdata),
    .q_pop(q_pop), .pop(pop), .empty(empty), .sample_out(sample_out),
    .channel_out(channel_out)
  );
endmodule
`default_nettype wire

@@ sv/asatm_front.sv @@
// ----------------------------------------------------------------------------
// asatm_front
// Accepts requests, clamps the drive per curve and forms the driven sample.
// ----------------------------------------------------------------------------
`default_nettype none
module asatm_front (
  input  wire asatm_pkg::cfg_t  cfg,
  input  wire                   push,
  input  wire                   q_full,
  input  wire signed [23:0]     sample_in,
  input  wire                   channel,
  output logic                  q_wr,
  output asatm_pkg::item_t      q_item
);
  import asatm_pkg::*;

  logic [15:0]        cap;
  logic [15:0]        d;
  logic signed [40:0] prod;

  always_comb begin
    case (cfg.mode)
      MODE_SOFT: cap = CAP_SOFT;
      MODE_TAPE: cap = CAP_TAPE;
      MODE_TUBE: cap = CAP_TUBE;
      default:   cap = CAP_SOFT;
    endcase
    d = (cfg.drive > cap) ? cap : cfg.drive;
    if (d < DRIVE_MIN) d = DRIVE_MIN;
    prod = $signed({1'b0, d}) * sample_in;
  end

  assign q_wr       = push && !q_full;
  assign q_item.x   = sample_in;
  assign q_item.ch  = channel;
  assign q_item.drv = prod[40:11];
endmodule
`default_nettype wire

@@ sv/asatm_fifo.sv @@
// ----------------------------------------------------------------------------
// asatm_fifo
// Short request queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module asatm_fifo (
  input  wire                clk,
  input  wire                rst,
  input  wire                wr,
  input  wire asatm_pkg::item_t wr_data,
  input  wire                rd,
  output asatm_pkg::item_t   rd_data,
  output logic               full,
  output logic               empty
);
  import asatm_pkg::*;

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
  end
endmodule
`default_nettype wire

@@ sv/asatm_div.sv @@
// ----------------------------------------------------------------------------
// asatm_div
// Restoring divider, one quotient bit per cycle, 24 bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none
module asatm_div (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  input  wire [29:0] rem_init,
  input  wire [23:0] low_bits,
  input  wire [29:0] den,
  output logic       done,
  output logic [23:0] quot
);
  logic [29:0] rem;
  logic [23:0] low;
  logic [29:0] den_r;
  logic [4:0]  cnt;
  logic        busy;
  logic [29:0] trial;

  assign trial = {rem[28:0], low[23]};

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      low   <= low_bits;
      den_r <= den;
    end else if (busy) begin
      rem  <= (trial >= den_r) ? trial - den_r : trial;
      quot <= {quot[22:0], trial >= den_r};
      low  <= {low[22:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd23;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ sv/asatm_back.sv @@
// ----------------------------------------------------------------------------
// asatm_back
// Shaping, tone filter, gain and mix sequencer with result register.
// ----------------------------------------------------------------------------
`default_nettype none
module asatm_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire asatm_pkg::cfg_t  cfg,
  input  wire                   q_empty,
  input  wire asatm_pkg::item_t q_item,
  output logic                  q_pop,
  input  wire                   pop,
  output logic                  empty,
  output logic signed [23:0]    sample_out,
  output logic                  channel_out
);
  import asatm_pkg::*;

  back_state_t state, state_next;

  logic signed [23:0] x_r;
  logic               ch_r;
  logic signed [29:0] drv_r;
  logic [28:0]        m_r;
  logic               neg_r;
  logic signed [26:0] s_r;
  logic [22:0]        lut_a, lut_d, tanh_r;
  logic [25:0]        frac_r;
  logic               sat_r;
  logic [22:0]        q_r;
  logic signed [23:0] c_r;
  logic signed [31:0] zn_r;
  logic signed [34:0] t_r, g_r;
  logic signed [23:0] y_r;
  logic signed [31:0] tmem [CHANNELS];
  logic               out_valid;

  logic               div_start, div_done;
  logic [23:0]        quot;
  logic [29:0]        den;

  // soft lookup
  localparam int POS_W = 29 + TBL_AW + 1;
  logic [POS_W-1:0]          pos;
  logic [POS_W-TANH_FRAC-1:0] idx_full;
  logic [TBL_AW:0]           idx;
  logic [22:0]               ta, tb;
  logic [48:0]               lp;
  logic [39:0]               np;
  logic [24:0]               r;
  // tape
  logic signed [23:0]  d24;
  logic signed [47:0]  sq, cp;
  logic [23:0]         cm;
  logic [55:0]         p3;
  logic [22:0]         d3;
  // filter and mix
  logic signed [31:0]  z;
  logic signed [32:0]  dz, dz2;
  logic signed [50:0]  pf, pt;
  logic signed [34:0]  zsum;
  logic signed [52:0]  pg;
  logic signed [35:0]  dx;
  logic signed [53:0]  pw;
  logic signed [36:0]  ysum;

  always_comb begin
    pos      = {{(TBL_AW+1){1'b0}}, m_r} * POS_W'(TANH_TABLE_DEPTH);
    idx_full = pos[POS_W-1:TANH_FRAC];
    idx      = {1'b0, idx_full[TBL_AW-1:0]};
    ta       = TANH_TBL[idx];
    tb       = TANH_TBL[idx + 1'b1];
    lp       = lut_d * frac_r;
    np       = tanh_r * cfg.norm;
    r        = np[39:15];
    d24      = drv_r[23:0];
    sq       = d24 * d24;
    cp       = $signed({1'b0, q_r}) * d24;
    cm       = c_r[23] ? 24'(-c_r) : 24'(c_r);
    p3       = cm * RECIP3;
    d3       = p3[55:33];
    den      = 30'd8388608 + (neg_r ? {2'b0, m_r[28:1]} : {1'b0, m_r});
    z        = tmem[ch_r];
    dz       = 33'(s_r) - 33'(z);
    pf       = frac_clamp(cfg.coef) * dz;
    zsum     = 35'(z) + pf[50:16];
    dz2      = 33'(s_r) - 33'(zn_r);
    pt       = frac_clamp(cfg.tone) * dz2;
    pg       = t_r * frac_clamp(cfg.gain);
    dx       = 36'(g_r) - 36'(x_r);
    pw       = frac_clamp(cfg.wet) * dx;
    ysum     = 37'(x_r) + 37'($signed(pw[51:16]));
  end

  asatm_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .rem_init({2'b0, m_r[28:1]}), .low_bits({m_r[0], 23'b0}), .den(den),
    .done(div_done), .quot(quot)
  );

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:   if (!q_empty) state_next = B_CLASS;
      B_CLASS: begin
        case (cfg.mode)
          MODE_SOFT: state_next = B_SOFT_A;
          MODE_TAPE: state_next = (m_r[28:23] != '0) ? B_FILT : B_TAPE_A;
          MODE_TUBE: state_next = B_TUBE;
          default:   state_next = B_FILT;
        endcase
      end
      B_SOFT_A: state_next = B_SOFT_B;
      B_SOFT_B: state_next = B_SOFT_C;
      B_SOFT_C: state_next = B_FILT;
      B_TAPE_A: state_next = B_TAPE_B;
      B_TAPE_B: state_next = B_TAPE_C;
      B_TAPE_C: state_next = B_FILT;
      B_TUBE:   if (div_done) state_next = B_FILT;
      B_FILT:   state_next = B_TONE;
      B_TONE:   state_next = B_GAIN;
      B_GAIN:   state_next = B_MIX;
      B_MIX:    state_next = B_DONE;
      B_DONE:   if (!out_valid) state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == B_IDLE) && !q_empty;
    div_start = (state == B_CLASS) && (cfg.mode == MODE_TUBE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        x_r   <= q_item.x;
        ch_r  <= q_item.ch;
        drv_r <= q_item.drv;
        neg_r <= q_item.drv[29];
        m_r   <= q_item.drv[29] ? 29'(-q_item.drv) : 29'(q_item.drv);
      end
      B_CLASS: begin
        case (cfg.mode)
          MODE_TAPE: s_r <= neg_r ? -TWO_THIRDS : TWO_THIRDS;
          MODE_BYPASS: s_r <= 27'(x_r);
          default: s_r <= s_r;
        endcase
      end
      B_SOFT_A: begin
        sat_r  <= idx_full >= (POS_W-TANH_FRAC)'(TANH_TABLE_DEPTH);
        lut_a  <= ta;
        lut_d  <= tb - ta;
        frac_r <= pos[TANH_FRAC-1:0];
      end
      B_SOFT_B: tanh_r <= sat_r ? TANH_TBL[TANH_TABLE_DEPTH] : lut_a + lp[48:26];
      B_SOFT_C: s_r <= neg_r ? -$signed({2'b0, r}) : $signed({2'b0, r});
      B_TAPE_A: q_r <= sq[45:23];
      B_TAPE_B: c_r <= cp[46:23];
      B_TAPE_C: s_r <= 27'(d24) - (c_r[23] ? -$signed({4'b0, d3}) : $signed({4'b0, d3}));
      B_TUBE:   s_r <= neg_r ? -$signed({3'b0, quot}) : $signed({3'b0, quot});
      B_FILT: begin
        if (zsum > 35'sd2147483647)       zn_r <= 32'sh7FFFFFFF;
        else if (zsum < -35'sd2147483648) zn_r <= 32'sh80000000;
        else                              zn_r <= zsum[31:0];
      end
      B_TONE: t_r <= 35'(zn_r) + pt[50:16];
      B_GAIN: g_r <= pg[50:16];
      B_MIX: begin
        if (ysum > 37'sd8388607)       y_r <= 24'sh7FFFFF;
        else if (ysum < -37'sd8388608) y_r <= 24'sh800000;
        else                           y_r <= ysum[23:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) tmem[i] <= '0;
    end else if (state == B_FILT) begin
      if (zsum > 35'sd2147483647)       tmem[ch_r] <= 32'sh7FFFFFFF;
      else if (zsum < -35'sd2147483648) tmem[ch_r] <= 32'sh80000000;
      else                              tmem[ch_r] <= zsum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_DONE && !out_valid) begin
      out_valid   <= 1'b1;
      sample_out  <= y_r;
      channel_out <= ch_r;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(sample_out)))
    else $error("result overwritten before pop");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == B_IDLE && !q_empty))
    else $error("queue popped outside idle");
  a_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == B_TUBE)
    else $error("divider finished outside tube step");
endmodule
`default_nettype wire
